// ===== hw/rtl/devex_price_argmax_assert.svh =====
// Assertion macros shared by the pricing block
`ifndef DEVEX_PRICE_ARGMAX_ASSERT_SVH
`define DEVEX_PRICE_ARGMAX_ASSERT_SVH

// Condition that holds at every clock edge out of reset
`define DPA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dpa: invariant violated");

// Condition that implies another in the same cycle
`define DPA_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dpa: implication violated");

// Condition that implies another in the next cycle
`define DPA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dpa: next-cycle implication violated");

`endif

// ===== hw/rtl/dpa_pkg.sv =====
package dpa_pkg;

    localparam int unsigned MAX_ENTRIES = 65536;
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = $clog2(QDEPTH);
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [47:0] PRICE_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] TOL_RESET   = 48'd17;

    typedef struct packed {
        logic [15:0]        entry_index;
        logic signed [47:0] violation;
        logic [47:0]        entry_weight;
        logic               last_entry;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [15:0] best_index;
        logic [47:0] best_price;
        logic [47:0] best_weight;
    } out_word_t;

    // Classified entry handed from front to back
    typedef struct packed {
        logic        cand;
        logic        last;
        logic [15:0] idx;
        logic [47:0] mag;
        logic [47:0] div;
        logic [47:0] weight;
    } job_t;

endpackage

// ===== hw/rtl/dpa_front.sv =====
module dpa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dpa_pkg::in_word_t in_word,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [47:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output dpa_pkg::job_t     q_job
);

    logic [47:0] tol_reg;
    logic [47:0] tol_next;
    logic [47:0] neg_v;
    logic [47:0] mag;
    logic        in_range;
    logic        cand;

    assign cfg_ready = 1'b1;
    assign tol_next  = (cfg_valid && cfg_ready) ? cfg_data : tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= dpa_pkg::TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    always_comb
    begin
        neg_v    = 48'd0 - in_word.violation;
        mag      = (neg_v == 48'd0) ? {1'b1, 47'd0} : neg_v;
        in_range = 32'(in_word.entry_index) < dpa_pkg::MAX_ENTRIES;
        cand     = in_word.violation[47] && in_range && (mag > tol_reg);
    end

    assign in_stall = q_full;

    // drop entries that can neither win nor close the scan
    assign q_push = in_valid && !in_stall && (cand || in_word.last_entry);

    always_comb
    begin
        q_job.cand   = cand;
        q_job.last   = in_word.last_entry;
        q_job.idx    = in_word.entry_index;
        q_job.mag    = mag;
        q_job.div    = (in_word.entry_weight < tol_reg) ? tol_reg : in_word.entry_weight;
        q_job.weight = in_word.entry_weight;
    end

endmodule

// ===== hw/rtl/dpa_queue.sv =====
module dpa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dpa_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output dpa_pkg::job_t pop_job,
    output logic          not_empty
);

    dpa_pkg::job_t                   mem [dpa_pkg::QDEPTH];
    logic [dpa_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dpa_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dpa_pkg::QCNT_W-1:0]      count_reg;

    assign full      = count_reg == dpa_pkg::QCNT_W'(dpa_pkg::QDEPTH);
    assign not_empty = count_reg != '0;
    assign pop_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == dpa_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == dpa_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/dpa_back.sv =====
`include "devex_price_argmax_assert.svh"

module dpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  dpa_pkg::job_t      q_job,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output dpa_pkg::out_word_t out_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg;
    dpa_pkg::job_t      job_reg;
    logic [1:0]         step_reg;
    logic [5:0]         cnt_reg;
    logic [95:0]        sq_reg;
    logic [47:0]        rem_reg;
    logic [47:0]        lo_reg;
    logic [47:0]        q_reg;
    logic [47:0]        run_best_price_reg;
    logic [15:0]        run_best_index_reg;
    logic [47:0]        run_best_weight_reg;
    logic               run_found_reg;
    logic               out_valid_reg;
    dpa_pkg::out_word_t out_word_reg;

    logic [23:0]        mul_a;
    logic [23:0]        mul_b;
    logic [47:0]        prod;
    logic [95:0]        prod_sh;
    logic [48:0]        r2;
    logic [48:0]        diff;
    logic               ge;
    logic               better;
    logic               can_fin;
    logic               fin_out;
    logic [47:0]        run_best_price_next;
    logic [15:0]        run_best_index_next;
    logic [47:0]        run_best_weight_next;
    logic               run_found_next;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // one 24x24 partial product per cycle
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                mul_a   = job_reg.mag[23:0];
                mul_b   = job_reg.mag[23:0];
            end
            2'd1:
            begin
                mul_a   = job_reg.mag[23:0];
                mul_b   = job_reg.mag[47:24];
            end
            2'd2:
            begin
                mul_a   = job_reg.mag[47:24];
                mul_b   = job_reg.mag[23:0];
            end
            default:
            begin
                mul_a   = job_reg.mag[47:24];
                mul_b   = job_reg.mag[47:24];
            end
        endcase
        prod = 48'(mul_a) * 48'(mul_b);
        unique case (step_reg)
            2'd0:    prod_sh = {48'd0, prod};
            2'd1:    prod_sh = {24'd0, prod, 24'd0};
            2'd2:    prod_sh = {24'd0, prod, 24'd0};
            default: prod_sh = {prod, 48'd0};
        endcase
    end

    always_comb
    begin
        r2   = {rem_reg, lo_reg[47]};
        ge   = r2 >= {1'b0, job_reg.div};
        diff = r2 - {1'b0, job_reg.div};
    end

    always_comb
    begin
        better  = job_reg.cand && (q_reg > run_best_price_reg);
        can_fin = !job_reg.last || !out_valid_reg || !out_stall;
        run_best_price_next  = better ? q_reg : run_best_price_reg;
        run_best_index_next  = better ? job_reg.idx : run_best_index_reg;
        run_best_weight_next = better ? job_reg.weight : run_best_weight_reg;
        run_found_next       = better ? 1'b1 : run_found_reg;
    end

    assign fin_out = (state_reg == ST_FIN) && can_fin && job_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            job_reg             <= '0;
            step_reg            <= '0;
            cnt_reg             <= '0;
            sq_reg              <= '0;
            rem_reg             <= '0;
            lo_reg              <= '0;
            q_reg               <= '0;
            run_best_price_reg  <= '0;
            run_best_index_reg  <= '0;
            run_best_weight_reg <= '0;
            run_found_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_word_reg        <= '0;
        end
        else
        begin
            if (fin_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg   <= q_job;
                        step_reg  <= '0;
                        sq_reg    <= '0;
                        q_reg     <= '0;
                        state_reg <= q_job.cand ? ST_MUL : ST_FIN;
                    end
                end
                ST_MUL:
                begin
                    sq_reg   <= sq_reg + prod_sh;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    // high half at or above the divisor: quotient needs more than 48 bits
                    if (sq_reg[95:48] >= job_reg.div)
                    begin
                        q_reg     <= dpa_pkg::PRICE_MAX;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        rem_reg   <= sq_reg[95:48];
                        lo_reg    <= sq_reg[47:0];
                        cnt_reg   <= 6'd47;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= ge ? diff[47:0] : r2[47:0];
                    lo_reg  <= {lo_reg[46:0], 1'b0};
                    q_reg   <= {q_reg[46:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (can_fin)
                    begin
                        state_reg <= ST_IDLE;
                        if (job_reg.last)
                        begin
                            out_word_reg.found       <= run_found_next;
                            out_word_reg.best_index  <= run_best_index_next;
                            out_word_reg.best_price  <= run_best_price_next;
                            out_word_reg.best_weight <= run_best_weight_next;
                            run_best_price_reg       <= '0;
                            run_best_index_reg       <= '0;
                            run_best_weight_reg      <= '0;
                            run_found_reg            <= 1'b0;
                        end
                        else
                        begin
                            run_best_price_reg  <= run_best_price_next;
                            run_best_index_reg  <= run_best_index_next;
                            run_best_weight_reg <= run_best_weight_next;
                            run_found_reg       <= run_found_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `DPA_ASSERT_ALWAYS(a_found_matches_price, run_found_reg == (run_best_price_reg != 48'd0))
    `DPA_ASSERT_IMP(a_rem_below_div, state_reg == ST_DIV, rem_reg < job_reg.div)
    `DPA_ASSERT_IMP(a_pop_only_idle, q_pop, state_reg == ST_IDLE)
    `DPA_ASSERT_NEXT(a_fin_last_sets_out, fin_out, out_valid_reg)

endmodule

// ===== hw/rtl/devex_price_argmax.sv =====
// Channel | Direction | Handshake                    | Word
// in      | input     | in_valid / in_stall          | dpa_pkg::in_word_t
// out     | output    | out_valid / out_stall        | dpa_pkg::out_word_t
// cfg     | input     | cfg_valid / cfg_ready        | tolerance, 48 bits
//
// Entries that are neither candidates nor last are dropped at the front, one per cycle
// unless the queue is full. A candidate in the back: pop, 4 partial products, check,
// 48 divide steps, finish; saturation skips the divide; a last non-candidate: pop, finish.
// The bit-serial divider sets the rate; a two-word queue lets the front keep taking words.
// rst_n is asynchronous, active low; tolerance resets to 17, running best to zero.
// A stalled result holds in the output register; the back waits at the finish step.
module devex_price_argmax (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dpa_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output dpa_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [47:0]        cfg_data
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    dpa_pkg::job_t push_job;
    dpa_pkg::job_t pop_job;

    dpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    dpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .not_empty (q_valid)
    );

    dpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// ===== tb/devex_price_argmax_tb.sv =====
`timescale 1ns / 1ps

module devex_price_argmax_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    dpa_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    dpa_pkg::out_word_t out_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [47:0]        cfg_data;

    localparam logic [47:0] SIGN_MIN = 48'h8000_0000_0000;

    logic [47:0] tol_q;
    logic [47:0] scan_price_q;
    logic [15:0] scan_index_q;
    logic [47:0] scan_weight_q;
    logic        scan_found_q;

    dpa_pkg::out_word_t winner_q[$];
    int          err_cnt;
    int          item_cnt;
    int          result_cnt;
    int          cand_cnt;

    devex_price_argmax u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact floor(mag^2 / div), saturated to 48 bits
    function automatic logic [47:0] devex_price(input logic [47:0] mag, input logic [47:0] div);
        logic [95:0] sq;
        logic [95:0] quo;
        begin
            if (div == 48'd0)
                return dpa_pkg::PRICE_MAX;
            sq  = {48'd0, mag} * {48'd0, mag};
            quo = sq / {48'd0, div};
            if (quo[95:48] != 48'd0)
                return dpa_pkg::PRICE_MAX;
            return quo[47:0];
        end
    endfunction

    task automatic track_entry(input dpa_pkg::in_word_t w);
        logic [47:0] mag;
        logic [47:0] div;
        logic [47:0] p;
        dpa_pkg::out_word_t r;
        begin
            if (w.violation[47] && (w.entry_index < dpa_pkg::MAX_ENTRIES))
            begin
                mag = 48'd0 - w.violation;
                if (mag == 48'd0)
                    mag = SIGN_MIN;
                if (mag > tol_q)
                begin
                    cand_cnt++;
                    div = (w.entry_weight < tol_q) ? tol_q : w.entry_weight;
                    p = devex_price(mag, div);
                    if (p > scan_price_q)
                    begin
                        scan_price_q  = p;
                        scan_index_q  = w.entry_index;
                        scan_weight_q = w.entry_weight;
                        scan_found_q  = 1'b1;
                    end
                end
            end
            if (w.last_entry)
            begin
                r.found       = scan_found_q;
                r.best_index  = scan_index_q;
                r.best_price  = scan_price_q;
                r.best_weight = scan_weight_q;
                winner_q.push_back(r);
                scan_price_q  = '0;
                scan_index_q  = '0;
                scan_weight_q = '0;
                scan_found_q  = 1'b0;
            end
        end
    endtask

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] exp);
        begin
            $display("%0t: %s got %h expected %h", $realtime, what, got, exp);
            err_cnt++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    // Random stall on the result side
    logic stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_mode)
        begin
            out_stall <= ($urandom_range(0, 3) == 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (winner_q.size() == 0)
            begin
                report("unexpected result word, best_index", 48'(out_word.best_index), 48'd0);
            end
            else
            begin
                automatic dpa_pkg::out_word_t e = winner_q.pop_front();
                result_cnt++;
                if (out_word.found != e.found)
                    report("found", out_word.found, e.found);
                if (out_word.best_index != e.best_index)
                    report("best_index", out_word.best_index, e.best_index);
                if (out_word.best_price != e.best_price)
                    report("best_price", out_word.best_price, e.best_price);
                if (out_word.best_weight != e.best_weight)
                    report("best_weight", out_word.best_weight, e.best_weight);
            end
        end
    end

    task automatic send_entry(input logic [15:0] idx, input logic [47:0] v,
                              input logic [47:0] w, input logic last);
        dpa_pkg::in_word_t x;
        int       g;
        begin
            x.entry_index  = idx;
            x.violation    = v;
            x.entry_weight = w;
            x.last_entry   = last;
            g = pick_gap();
            // drop valid only for a gap; a word that follows at once keeps it high
            if (g > 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_word  <= x;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            track_entry(x);
            item_cnt++;
        end
    endtask

    task automatic drain();
        int guard;
        begin
            in_valid <= 1'b0;
            guard = 0;
            while (winner_q.size() != 0 && guard < 200000)
            begin
                @(posedge clk);
                guard++;
            end
            // a candidate still in the divider can outlive the last result
            repeat (200) @(posedge clk);
        end
    endtask

    task automatic set_tolerance(input logic [47:0] t);
        begin
            drain();
            cfg_valid <= 1'b1;
            cfg_data  <= t;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            tol_q = t;
            @(posedge clk);
        end
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    function automatic logic [47:0] rand_violation();
        int r;
        logic [47:0] m;
        begin
            r = $urandom_range(0, 9);
            m = rand48() >> $urandom_range(0, 47);
            if (r < 7)
                return 48'd0 - m;
            if (r < 8)
                return rand48();
            if (r < 9)
                return SIGN_MIN;
            return 48'd0 - tol_q;
        end
    endfunction

    function automatic logic [47:0] rand_weight();
        int r;
        begin
            r = $urandom_range(0, 5);
            if (r == 0)
                return 48'd0;
            if (r == 1)
                return tol_q;
            if (r == 2)
                return dpa_pkg::PRICE_MAX;
            return rand48() >> $urandom_range(0, 47);
        end
    endfunction

    task automatic test_directed();
        begin
            // empty scan: single non-candidate last word
            send_entry(16'd0, 48'd5, 48'd1, 1'b1);
            send_entry(16'hFFFF, SIGN_MIN, 48'd0, 1'b0);
            send_entry(16'd1, 48'hFFFF_FFFF_FFFF, dpa_pkg::PRICE_MAX, 1'b0);
            send_entry(16'd2, 48'd0 - 48'd17, 48'd3, 1'b0);
            send_entry(16'd3, 48'd0 - 48'd18, 48'd3, 1'b1);
            // ties: first wins
            send_entry(16'd10, 48'd0 - 48'd1000, 48'd500, 1'b0);
            send_entry(16'd11, 48'd0 - 48'd1000, 48'd500, 1'b0);
            send_entry(16'd12, 48'd0 - 48'd100, 48'd1, 1'b1);
            send_entry(16'd20, 48'h7FFF_FFFF_FFFF, dpa_pkg::PRICE_MAX, 1'b1);
            send_entry(16'd21, 48'd0 - 48'd1, dpa_pkg::PRICE_MAX, 1'b0);
            send_entry(16'd22, 48'd0 - 48'h0100_0000, 48'h0100_0000, 1'b1);
            set_tolerance(48'd0);
            send_entry(16'd30, 48'd0 - 48'd1, 48'd0, 1'b0);
            send_entry(16'd31, 48'd0 - 48'd2, 48'd0, 1'b1);
            send_entry(16'd32, 48'd0 - 48'd3, 48'd9, 1'b1);
            set_tolerance(dpa_pkg::PRICE_MAX);
            send_entry(16'd40, SIGN_MIN, 48'd0, 1'b0);
            send_entry(16'd41, 48'd0 - 48'd1, 48'd1, 1'b1);
            set_tolerance(48'd1);
            send_entry(16'd50, 48'd0 - 48'd2, 48'd0, 1'b0);
            send_entry(16'd51, SIGN_MIN, 48'd1, 1'b1);
        end
    endtask

    task automatic test_random_scans(input int n_items);
        int sent;
        int len;
        int i;
        begin
            sent = 0;
            while (sent < n_items)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                begin
                    send_entry(16'($urandom_range(0, 65535)), rand_violation(),
                               rand_weight(), i == len - 1);
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        stall_mode = 1'b0;
        tol_q      = dpa_pkg::TOL_RESET;
        scan_price_q  = '0;
        scan_index_q  = '0;
        scan_weight_q = '0;
        scan_found_q  = 1'b0;
        err_cnt    = 0;
        item_cnt   = 0;
        result_cnt = 0;
        cand_cnt   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        stall_mode = 1'b1;
        set_tolerance(48'd17);
        test_random_scans(260);
        set_tolerance(48'h0000_0000_1000);
        test_random_scans(260);
        stall_mode = 1'b0;
        set_tolerance(48'd0);
        test_random_scans(260);
        stall_mode = 1'b1;
        set_tolerance(48'h0000_0100_0000);
        test_random_scans(250);
        drain();

        $display("Ran %0d entries (%0d candidates) and checked %0d scan results",
                 item_cnt, cand_cnt, result_cnt);
        $display("Tolerances covered: 0, 1, 17, 2^12, 2^24 and all ones");
        if (err_cnt == 0 && winner_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #400ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
